/* rtl/mtdk_pkg.sv */
// Shared types and constants for the motion-to-direction-keys block.
// Used by mtdk_step and motion_to_direction_keys; no dependencies.
`default_nettype none

package mtdk_pkg;

    // Field widths
    localparam int unsigned STEP_W   = 14;
    localparam int unsigned MS_W     = 15;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned ACC_W    = 16;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    // Defaults
    localparam int unsigned RELEASE_DELAY_TICKS_DEF = 10;
    localparam logic [STEP_W-1:0] X_STEP_RST     = STEP_W'(10);
    localparam logic [STEP_W-1:0] Y_STEP_RST     = STEP_W'(10);
    localparam logic [MS_W-1:0]   RATE_LIMIT_RST = MS_W'(50);

    // Saturation point of the ms counter and of the clamp limit
    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    // Opcodes, axis codes, directions
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_MOTION = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_STEP      = 3'd0,
        CFG_Y_STEP      = 3'd1,
        CFG_RATE_LIMIT  = 3'd2,
        CFG_X_INVERT    = 3'd3,
        CFG_Y_INVERT    = 3'd4,
        CFG_CLEAR_OTHER = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
        logic [MS_W-1:0]   swallow_ms;
        logic              x_negate;
        logic              y_negate;
        logic              clear_other_axis;
    } cfg_t;

    typedef struct packed {
        logic                     op;
        logic [1:0]               axis;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x_accum;
        logic signed [ACC_W-1:0] y_accum;
        logic                    seen_xy;
        logic                    busy;
        logic [CNT_W-1:0]        release_countdown;
        logic [MS_W-1:0]         since_trigger_ms;
        logic [1:0]              held_dir;
    } state_t;

    typedef struct packed {
        logic       passed_through;
        logic       press_valid;
        logic [1:0] press_dir;
        logic       release_valid;
        logic [1:0] release_dir;
    } result_t;

endpackage

`default_nettype wire

/* rtl/mtdk_step.sv */
// Next-state and result logic for one request: accumulate, clamp, trigger.
// Purely combinational; depends on mtdk_pkg.
`default_nettype none

module mtdk_step #(
    parameter int unsigned RELEASE_DELAY_TICKS = mtdk_pkg::RELEASE_DELAY_TICKS_DEF
) (
    input  mtdk_pkg::cfg_t    cfg,
    input  mtdk_pkg::state_t  st,
    input  mtdk_pkg::item_t   item,
    output mtdk_pkg::state_t  st_next,
    output mtdk_pkg::result_t res
);
    import mtdk_pkg::*;

    // Clamp a wide sum to +/- min(3*step, 32767)
    function automatic logic signed [ACC_W-1:0] clamp_axis(
        input logic signed [17:0] sum,
        input logic [STEP_W-1:0]  step
    );
        logic [15:0]        lim3;
        logic [MS_W-1:0]    lim;
        logic signed [17:0] lim_s;
        lim3  = {1'b0, step, 1'b0} + {2'b00, step};
        lim   = (lim3 > {1'b0, MS_MAX}) ? MS_MAX : lim3[MS_W-1:0];
        lim_s = $signed({3'b000, lim});
        if (sum > lim_s)
            clamp_axis = lim_s[ACC_W-1:0];
        else if (sum < -lim_s)
            clamp_axis = 16'(-lim_s);
        else
            clamp_axis = sum[ACC_W-1:0];
    endfunction

    logic signed [17:0]   v_ext;
    logic signed [17:0]   x_add;
    logic signed [17:0]   y_add;
    logic signed [ACC_W-1:0] x_cl;
    logic signed [ACC_W-1:0] y_cl;
    logic signed [16:0]   x_c17;
    logic signed [16:0]   y_c17;
    logic signed [16:0]   xs;
    logic signed [16:0]   ys;
    logic                 seen;

    // Motion datapath
    always_comb
    begin
        v_ext = 18'(item.value);
        x_add = (item.axis == AXIS_X) ? (cfg.x_negate ? -v_ext : v_ext) : '0;
        y_add = (item.axis == AXIS_Y) ? (cfg.y_negate ? -v_ext : v_ext) : '0;
        x_cl  = clamp_axis(18'(st.x_accum) + x_add, cfg.x_step);
        y_cl  = clamp_axis(18'(st.y_accum) + y_add, cfg.y_step);
        x_c17 = 17'(x_cl);
        y_c17 = 17'(y_cl);
        xs    = $signed({3'b000, cfg.x_step});
        ys    = $signed({3'b000, cfg.y_step});
        seen  = st.seen_xy || (item.axis == AXIS_X) || (item.axis == AXIS_Y);
    end

    // Request decode and state update
    always_comb
    begin
        logic       trig;
        logic [1:0] dir;
        trig    = 1'b0;
        dir     = DIR_RIGHT;
        st_next = st;
        res     = '0;

        if (item.op == OP_TICK)
        begin
            if (st.since_trigger_ms != MS_MAX)
                st_next.since_trigger_ms = st.since_trigger_ms + 1'b1;
            if (st.busy)
            begin
                if (st.release_countdown <= CNT_W'(1))
                begin
                    st_next.release_countdown = '0;
                    st_next.busy              = 1'b0;
                    res.release_valid         = 1'b1;
                    res.release_dir           = st.held_dir;
                end
                else
                    st_next.release_countdown = st.release_countdown - 1'b1;
            end
        end
        else if (item.value == '0)
            res.passed_through = 1'b1;
        else if (st.since_trigger_ms < cfg.swallow_ms)
            res.passed_through = 1'b0;
        else
        begin
            st_next.seen_xy = seen;
            st_next.x_accum = x_cl;
            st_next.y_accum = y_cl;
            if (!seen)
                res.passed_through = 1'b1;
            else
            begin
                // X has priority over Y
                if (x_c17 >= xs)
                begin
                    st_next.x_accum = 16'(x_c17 - xs);
                    dir  = DIR_RIGHT;
                    trig = 1'b1;
                end
                else if (x_c17 <= -xs)
                begin
                    st_next.x_accum = 16'(x_c17 + xs);
                    dir  = DIR_LEFT;
                    trig = 1'b1;
                end

                if (trig)
                begin
                    if (cfg.clear_other_axis)
                        st_next.y_accum = '0;
                end
                else
                begin
                    if (y_c17 >= ys)
                    begin
                        st_next.y_accum = 16'(y_c17 - ys);
                        dir  = DIR_DOWN;
                        trig = 1'b1;
                    end
                    else if (y_c17 <= -ys)
                    begin
                        st_next.y_accum = 16'(y_c17 + ys);
                        dir  = DIR_UP;
                        trig = 1'b1;
                    end
                    if (trig && cfg.clear_other_axis)
                        st_next.x_accum = '0;
                end

                // Press only when idle; a busy trigger just retargets the release
                if (trig)
                begin
                    st_next.held_dir = dir;
                    if (!st.busy)
                    begin
                        st_next.busy              = 1'b1;
                        st_next.since_trigger_ms  = '0;
                        st_next.release_countdown = CNT_W'(RELEASE_DELAY_TICKS);
                        res.press_valid           = 1'b1;
                        res.press_dir             = dir;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/motion_to_direction_keys.sv */
// Motion to direction keys: input register, step logic, result register.
// Depends on mtdk_pkg and mtdk_step.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per accepted edge:
//   op (tick or motion), axis and a signed 16-bit value. Each request yields
//   exactly one result on the output channel (out_valid / out_stall):
//   passed_through, press_valid/press_dir, release_valid/release_dir.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   six registers; cfg_ready is always high. Write config only while idle.
// Result: the step logic works on the input register; its result is registered when the output is free.
// Throughput: one request per cycle while out_stall holds no result; the per-axis accumulators
//   are updated by combinational add/clamp/compare logic, so requests follow each other
//   back to back.
// Reset: rst_n low clears accumulators, counters, busy and both valid flags
//   and loads register defaults (steps 10, rate limit 50 ms, no invert).
// Stall: while out_stall holds a result, one more request is taken into the
//   input register; after that in_stall goes high until the result drains.
`default_nettype none

module motion_to_direction_keys #(
    parameter int unsigned RELEASE_DELAY_TICKS = mtdk_pkg::RELEASE_DELAY_TICKS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              op,
    input  wire logic [1:0]                        axis,
    input  wire logic signed [mtdk_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   passed_through,
    output logic                                   press_valid,
    output logic [1:0]                             press_dir,
    output logic                                   release_valid,
    output logic [1:0]                             release_dir,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mtdk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mtdk_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtdk_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;
    logic    accept;

    // Handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_step           <= X_STEP_RST;
            cfg_reg.y_step           <= Y_STEP_RST;
            cfg_reg.swallow_ms       <= RATE_LIMIT_RST;
            cfg_reg.x_negate         <= 1'b0;
            cfg_reg.y_negate         <= 1'b0;
            cfg_reg.clear_other_axis <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_X_STEP:      cfg_reg.x_step           <= cfg_data[STEP_W-1:0];
                CFG_Y_STEP:      cfg_reg.y_step           <= cfg_data[STEP_W-1:0];
                CFG_RATE_LIMIT:  cfg_reg.swallow_ms       <= cfg_data[MS_W-1:0];
                CFG_X_INVERT:    cfg_reg.x_negate         <= cfg_data[0];
                CFG_Y_INVERT:    cfg_reg.y_negate         <= cfg_data[0];
                CFG_CLEAR_OTHER: cfg_reg.clear_other_axis <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Step logic
    mtdk_step #(
        .RELEASE_DELAY_TICKS(RELEASE_DELAY_TICKS)
    ) u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= accept;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op    <= op;
            item_reg.axis  <= axis;
            item_reg.value <= value;
        end
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign passed_through = res_reg.passed_through;
    assign press_valid    = res_reg.press_valid;
    assign press_dir      = res_reg.press_dir;
    assign release_valid  = res_reg.release_valid;
    assign release_dir    = res_reg.release_dir;

`ifndef SYNTHESIS
    // A press comes only from motion and a release only from a tick
    a_press_xor_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(press_valid && release_valid))
        else $error("press and release in one result");

    // Passed-through motion never presses
    a_pass_no_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && passed_through |-> !press_valid)
        else $error("press on passed-through motion");

    // An issued press leaves the block busy
    a_press_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && res_next.press_valid |=> state_reg.busy)
        else $error("busy not set after press");

    // Nothing to hold back while the result register is empty
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

/* tb/tb_motion_to_direction_keys.sv */
`timescale 1ns / 1ps
// Testbench for motion_to_direction_keys: directed and random requests under random idling,
// with an in-order key event predictor and field-by-field result checks.
// Depends on mtdk_pkg and the motion_to_direction_keys RTL.

module tb_motion_to_direction_keys;
    import mtdk_pkg::*;

    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_REQUESTS = 200;
    localparam int         HOLD_PHASE     = 5;
    // relative codes that are neither X nor Y
    localparam logic [1:0] AXIS_WHEEL     = 2'd2;
    localparam logic [1:0] AXIS_MISC      = 2'd3;

    // DUT ports
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         op        = OP_TICK;
    logic [1:0]                   axis      = AXIS_X;
    logic signed [VALUE_W-1:0]    value     = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         passed_through;
    logic                         press_valid;
    logic [1:0]                   press_dir;
    logic                         release_valid;
    logic [1:0]                   release_dir;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = CFG_X_STEP;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;

    // Predictor copy of registers and state
    int         step_x         = X_STEP_RST;
    int         step_y         = Y_STEP_RST;
    int         rate_ms        = RATE_LIMIT_RST;
    logic       inv_x          = 1'b0;
    logic       inv_y          = 1'b0;
    logic       clear_other    = 1'b0;
    int         acc_x          = 0;
    int         acc_y          = 0;
    logic       xy_seen        = 1'b0;
    logic       key_busy       = 1'b0;
    int         release_left   = 0;
    int         ms_since_press = 0;
    logic [1:0] held_key       = DIR_RIGHT;

    // Request and result bookkeeping
    item_t      pending_requests[$];
    result_t    expected_keys[$];
    item_t      cur_req;
    int         idle_pct      = 0;
    int         hold_requests = 0;
    int         hold_done     = 0;
    int         hold_left     = 0;
    int         send_gap      = 0;
    int         stall_left    = 0;
    int         n_accepted    = 0;
    int         n_presses     = 0;
    int         n_releases    = 0;
    int         n_passed      = 0;
    int         n_settings    = 0;
    int         n_errors      = 0;
    int         n_cycles      = 0;

    motion_to_direction_keys i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .axis           (axis),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .passed_through (passed_through),
        .press_valid    (press_valid),
        .press_dir      (press_dir),
        .release_valid  (release_valid),
        .release_dir    (release_dir),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // Accumulator clamp to +/- three steps, limit saturating at 32767
    function automatic int clamp_axis(int acc, int step);
        int lim;
        lim = (step * 3 > 32767) ? 32767 : step * 3;
        if (acc > lim)
            return lim;
        if (acc < -lim)
            return -lim;
        return acc;
    endfunction

    // Key events caused by one request; advances the predictor state
    function automatic result_t predict_keys(item_t req);
        result_t    r;
        int         v;
        logic       trig;
        logic [1:0] dir;
        r    = '0;
        trig = 1'b0;
        dir  = DIR_RIGHT;
        v    = $signed(req.value);
        if (req.op == OP_TICK) begin
            if (ms_since_press < MS_MAX)
                ms_since_press++;
            if (key_busy) begin
                if (release_left > 0)
                    release_left--;
                if (release_left == 0) begin
                    r.release_valid = 1'b1;
                    r.release_dir   = held_key;
                    key_busy        = 1'b0;
                end
            end
        end else if (v == 0) begin
            r.passed_through = 1'b1;
        end else if (ms_since_press >= rate_ms) begin
            if (req.axis == AXIS_X) begin
                xy_seen = 1'b1;
                acc_x  += inv_x ? -v : v;
            end else if (req.axis == AXIS_Y) begin
                xy_seen = 1'b1;
                acc_y  += inv_y ? -v : v;
            end
            acc_x = clamp_axis(acc_x, step_x);
            acc_y = clamp_axis(acc_y, step_y);
            if (!xy_seen) begin
                r.passed_through = 1'b1;
            end else begin
                // X has priority over Y
                if (acc_x >= step_x) begin
                    acc_x -= step_x;
                    dir    = DIR_RIGHT;
                    trig   = 1'b1;
                end else if (acc_x <= -step_x) begin
                    acc_x += step_x;
                    dir    = DIR_LEFT;
                    trig   = 1'b1;
                end
                if (trig) begin
                    if (clear_other)
                        acc_y = 0;
                end else begin
                    if (acc_y >= step_y) begin
                        acc_y -= step_y;
                        dir    = DIR_DOWN;
                        trig   = 1'b1;
                    end else if (acc_y <= -step_y) begin
                        acc_y += step_y;
                        dir    = DIR_UP;
                        trig   = 1'b1;
                    end
                    if (trig && clear_other)
                        acc_x = 0;
                end
                // a trigger while busy only retargets the pending release
                if (trig) begin
                    held_key = dir;
                    if (!key_busy) begin
                        key_busy       = 1'b1;
                        ms_since_press = 0;
                        release_left   = RELEASE_DELAY_TICKS_DEF % 256;
                        r.press_valid  = 1'b1;
                        r.press_dir    = dir;
                    end
                end
            end
        end
        return r;
    endfunction

    // Random request: a tick, zero or other-axis motion, or X/Y motion mostly near its step
    function automatic item_t random_request();
        item_t req;
        int    sel;
        int    span;
        sel       = $urandom_range(0, 99);
        req.op    = OP_MOTION;
        req.axis  = 2'($urandom_range(0, 1));
        req.value = VALUE_W'($urandom);
        if (sel < 40) begin
            req.op   = OP_TICK;
            req.axis = 2'($urandom_range(0, 3));
        end else if (sel < 45) begin
            req.axis  = 2'($urandom_range(0, 3));
            req.value = '0;
        end else if (sel < 50) begin
            req.axis = $urandom_range(0, 1) ? AXIS_WHEEL : AXIS_MISC;
        end else if (sel >= 56) begin
            span      = (req.axis == AXIS_X) ? step_x : step_y;
            req.value = VALUE_W'($urandom_range(1, 2 * span + 1));
            if ($urandom_range(0, 1))
                req.value = -req.value;
        end
        return req;
    endfunction

    task automatic queue_request(logic req_op, logic [1:0] req_axis, int req_value);
        item_t req;
        req.op    = req_op;
        req.axis  = req_axis;
        req.value = VALUE_W'(req_value);
        pending_requests.push_back(req);
    endtask

    // One register write; the predictor copy follows at the write edge
    task automatic write_reg(cfg_idx_t idx, int unsigned data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_X_STEP:      step_x      = data % (1 << STEP_W);
            CFG_Y_STEP:      step_y      = data % (1 << STEP_W);
            CFG_RATE_LIMIT:  rate_ms     = data % (1 << MS_W);
            CFG_X_INVERT:    inv_x       = data[0];
            CFG_Y_INVERT:    inv_y       = data[0];
            CFG_CLEAR_OTHER: clear_other = data[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_registers(int unsigned xs, int unsigned ys, int unsigned rms,
                                     int unsigned xi, int unsigned yi, int unsigned co);
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
        write_reg(CFG_RATE_LIMIT, rms);
        write_reg(CFG_X_INVERT, xi);
        write_reg(CFG_Y_INVERT, yi);
        write_reg(CFG_CLEAR_OTHER, co);
        n_settings++;
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_keys.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Request driver: predicts on acceptance, then offers the next request or idles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_keys.push_back(predict_keys(cur_req));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_pct) begin
                    send_gap <= $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_req   = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    op       <= cur_req.op;
                    axis     <= cur_req.axis;
                    value    <= cur_req.value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver stall: long hold on demand, else random bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_done != hold_requests) begin
            hold_done <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 9);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_keys.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                n_errors++;
            end else begin
                want = expected_keys.pop_front();
                check_field("passed_through", want.passed_through, passed_through);
                check_field("press_valid", want.press_valid, press_valid);
                check_field("press_dir", want.press_dir, press_dir);
                check_field("release_valid", want.release_valid, release_valid);
                check_field("release_dir", want.release_dir, release_dir);
                n_presses  += want.press_valid;
                n_releases += want.release_valid;
                n_passed   += want.passed_through;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_keys.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int p;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 20;

        // pass-through cases, full-scale motion, retarget while busy, release
        program_registers(10, 10, 0, 0, 0, 0);
        queue_request(OP_TICK, AXIS_X, 0);
        queue_request(OP_MOTION, AXIS_X, 0);
        queue_request(OP_MOTION, AXIS_WHEEL, 7);
        queue_request(OP_MOTION, AXIS_X, 32767);
        queue_request(OP_MOTION, AXIS_X, -32768);
        queue_request(OP_MOTION, AXIS_MISC, 100);
        repeat (10) queue_request(OP_TICK, AXIS_Y, -1);
        queue_request(OP_MOTION, AXIS_Y, -12);
        wait_drained();

        // inverted axes, other axis cleared, motion inside the rate limit
        program_registers(10, 10, 3, 1, 1, 1);
        queue_request(OP_MOTION, AXIS_X, -32768);
        repeat (3) queue_request(OP_TICK, AXIS_X, 32767);
        queue_request(OP_MOTION, AXIS_X, -32768);
        queue_request(OP_MOTION, AXIS_Y, 25);
        wait_drained();

        // zero step on X, clamp limit saturated on Y
        program_registers(0, 16383, 0, 0, 0, 0);
        queue_request(OP_MOTION, AXIS_Y, 32767);
        queue_request(OP_MOTION, AXIS_Y, -1);
        queue_request(OP_MOTION, AXIS_X, 5);
        wait_drained();

        // random phases, one register setting each
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_registers(1, 1, 0, 0, 0, 1);
                1: program_registers(0, 0, 0, 1, 0, 0);
                2: program_registers(16383, 10922, 32767, 1, 1, 1);
                3: program_registers(10922, 16383, 0, 0, 1, 0);
                4: program_registers($urandom_range(0, 32767), $urandom_range(0, 32767),
                                     $urandom_range(0, 32767), $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 1));
                default: program_registers($urandom_range(1, 40), $urandom_range(1, 40),
                                           $urandom_range(0, 20), $urandom_range(0, 1),
                                           $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            idle_pct = (p >= RANDOM_PHASES - 2) ? 0 : $urandom_range(5, 30);
            repeat (PHASE_REQUESTS) pending_requests.push_back(random_request());
            // receiver holds off while the sender keeps offering
            if (p == HOLD_PHASE)
                hold_requests++;
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("Checked %0d requests over %0d register settings.", n_accepted, n_settings);
        $display("Key presses %0d, releases %0d, pass-throughs %0d.",
                 n_presses, n_releases, n_passed);
        if (n_errors == 0 && expected_keys.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
